// ----- rtl/core/tkst_pkg.sv -----
// Shared types, constants and helpers of the top-K score table.
package tkst_pkg;

  localparam int NUM_BANKS   = 4;
  localparam int TABLE_DEPTH = 8;
  localparam int ENTRIES     = NUM_BANKS * TABLE_DEPTH;
  localparam int ADDR_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W      = $clog2(TABLE_DEPTH);

  localparam int SCORE_W     = 16;
  localparam int TIME_W      = 16;
  localparam int NAME_HEAD_W = 64;
  localparam int NAME_TAIL_W = 24;
  localparam int NAME_W      = NAME_HEAD_W + NAME_TAIL_W;
  localparam int NAME_BYTES  = NAME_W / 8;
  localparam int BANK_W      = 2;
  localparam int RANK_IN_W   = 3;
  localparam int PLACED_W    = 4;

  typedef enum logic {
    MODE_SUBMIT = 1'b0,
    MODE_READ   = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUB,
    ST_RDATA,
    ST_EMIT
  } tkst_state_e;

  typedef struct packed {
    logic [SCORE_W-1:0]     score;
    logic [TIME_W-1:0]      etime;
    logic [NAME_TAIL_W-1:0] name_tail;
    logic [NAME_HEAD_W-1:0] name_head;
  } entry_t;

  typedef struct packed {
    logic                   accepted;
    logic [PLACED_W-1:0]    placed_rank;
    logic [SCORE_W-1:0]     entry_score;
    logic [TIME_W-1:0]      entry_time;
    logic [NAME_HEAD_W-1:0] entry_name_head;
    logic [NAME_TAIL_W-1:0] entry_name_tail;
  } rsp_t;

  function automatic logic [ADDR_W-1:0] entry_addr(logic [BANK_W-1:0] bank,
                                                   logic [RANK_W-1:0] rank);
    return ADDR_W'(int'(bank) * TABLE_DEPTH + int'(rank));
  endfunction

  // Zero every byte after the first zero byte; tail sits above head.
  function automatic logic [NAME_W-1:0] trim_name(logic [NAME_HEAD_W-1:0] head,
                                                  logic [NAME_TAIL_W-1:0] tail);
    logic [NAME_W-1:0] name;
    logic              alive;
    name  = {tail, head};
    alive = 1'b1;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (name[8*i +: 8] == 8'h00) alive = 1'b0;
      if (!alive) name[8*i +: 8] = 8'h00;
    end
    return name;
  endfunction

endpackage

// ----- rtl/core/tkst_req_if.sv -----
// Request channel of the top-K score table: submit or read transaction.
interface tkst_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  bank;
  logic [2:0]  rank;
  logic [15:0] new_score;
  logic [15:0] new_time;
  logic [63:0] name_head;
  logic [23:0] name_tail;

  modport source (output valid, mode, bank, rank, new_score, new_time, name_head, name_tail,
                  input ready);
  modport sink   (input valid, mode, bank, rank, new_score, new_time, name_head, name_tail,
                  output ready);
endinterface

// ----- rtl/core/tkst_rsp_if.sv -----
// Response channel of the top-K score table: one result per request transaction.
interface tkst_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  placed_rank;
  logic [15:0] entry_score;
  logic [15:0] entry_time;
  logic [63:0] entry_name_head;
  logic [23:0] entry_name_tail;

  modport source (output valid, accepted, placed_rank, entry_score, entry_time,
                  entry_name_head, entry_name_tail, input ready);
  modport sink   (input valid, accepted, placed_rank, entry_score, entry_time,
                  entry_name_head, entry_name_tail, output ready);
endinterface

// ----- rtl/core/top_k_score_table_unit.sv -----
// Top-K score table: per-bank descending tables in one memory, sorted insertion by walk.
//
// All NUM_BANKS x TABLE_DEPTH entries live in a single synchronous memory with one read
// and one write port; a flip-flop valid bit per entry makes every entry read as zero after
// reset, so no clearing pass is needed. A submit walks its bank from rank 0 down, one entry
// per cycle: it reads an entry, and from the first entry with a lower score onward writes
// the carried entry back and carries the old one, so the last entry drops out. A submit to
// a bank out of range skips the walk and goes straight to the emit state, and a read goes
// through the read-data state first. One request is in work at a time; a new request is
// taken while the previous result still waits in the output register.
module top_k_score_table_unit
  import tkst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tkst_req_if.sink    req_i,
  tkst_rsp_if.source  rsp_o
);

  tkst_state_e       state_q, state_d;
  entry_t            mem [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  entry_t            rd_data_q;
  logic              rd_vld_q;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  entry_t            wr_data;
  entry_t            stored;
  entry_t            cur_q;
  logic [BANK_W-1:0] bank_q;
  logic [RANK_W-1:0] k_q, pos_q;
  logic              placed_q, is_read_q;
  logic              req_fire, bank_ok, rank_ok, k_last, ins, emit_fire;
  logic [NAME_W-1:0] in_name;
  rsp_t              out_q;
  logic              out_valid_q;

  assign req_fire  = req_i.valid && req_i.ready;
  assign bank_ok   = int'(req_i.bank) < NUM_BANKS;
  assign rank_ok   = int'(req_i.rank) < TABLE_DEPTH;
  assign k_last    = k_q == RANK_W'(TABLE_DEPTH - 1);
  assign stored    = rd_vld_q ? rd_data_q : '0;
  assign ins       = placed_q || (stored.score < cur_q.score);
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || rsp_o.ready);
  assign in_name   = trim_name(req_i.name_head, req_i.name_tail);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.mode == MODE_READ) state_d = ST_RDATA;
          else if (bank_ok) state_d = ST_SUB;
          else state_d = ST_EMIT;
        end
      end
      ST_SUB: begin
        if (k_last) state_d = ST_EMIT;
      end
      ST_RDATA: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = entry_addr(req_i.bank, RANK_W'(req_i.rank));
    wr_en       = 1'b0;
    wr_addr     = entry_addr(bank_q, k_q);
    wr_data     = cur_q;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_fire) begin
          if (req_i.mode == MODE_READ) begin
            rd_en = bank_ok && rank_ok;
          end else begin
            rd_en   = bank_ok;
            rd_addr = entry_addr(req_i.bank, '0);
          end
        end
      end
      ST_SUB: begin
        wr_en = ins;
        if (!k_last) begin
          rd_en   = 1'b1;
          rd_addr = entry_addr(bank_q, RANK_W'(k_q + 1'b1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      rd_vld_q <= rd_en && vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      placed_q    <= 1'b0;
      is_read_q   <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= emit_fire || (out_valid_q && !rsp_o.ready);
      case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            placed_q  <= 1'b0;
            is_read_q <= req_i.mode == MODE_READ;
            k_q       <= '0;
          end
        end
        ST_SUB: begin
          k_q <= RANK_W'(k_q + 1'b1);
          if (ins && !placed_q) placed_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          cur_q.score     <= req_i.new_score;
          cur_q.etime     <= req_i.new_time;
          cur_q.name_tail <= in_name[NAME_W-1 -: NAME_TAIL_W];
          cur_q.name_head <= in_name[NAME_HEAD_W-1:0];
          bank_q          <= req_i.bank;
        end
      end
      ST_SUB: begin
        if (ins) cur_q <= stored;
        if (ins && !placed_q) pos_q <= k_q;
      end
      ST_RDATA: cur_q <= stored;
      default: ;
    endcase
    if (emit_fire) begin
      out_q.accepted        <= placed_q;
      out_q.placed_rank     <= placed_q ? PLACED_W'(pos_q) : PLACED_W'(TABLE_DEPTH);
      out_q.entry_score     <= is_read_q ? cur_q.score : '0;
      out_q.entry_time      <= is_read_q ? cur_q.etime : '0;
      out_q.entry_name_head <= is_read_q ? cur_q.name_head : '0;
      out_q.entry_name_tail <= is_read_q ? cur_q.name_tail : '0;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.accepted        = out_q.accepted;
  assign rsp_o.placed_rank     = out_q.placed_rank;
  assign rsp_o.entry_score     = out_q.entry_score;
  assign rsp_o.entry_time      = out_q.entry_time;
  assign rsp_o.entry_name_head = out_q.entry_name_head;
  assign rsp_o.entry_name_tail = out_q.entry_name_tail;

endmodule
